// File: hdl/prct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prct_pkg
// Shared types and constants for the paced reveal channel table.
// ----------------------------------------------------------------------------
package prct_pkg;

  localparam int SLOTS = 8;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_NOTEXT  = 3'd0,
    ST_DONE    = 3'd1,
    ST_ERROR   = 3'd2,
    ST_CREATED = 3'd3,
    ST_WAITING = 3'd4,
    ST_ADVANCE = 3'd5,
    ST_UPDATED = 3'd6
  } status_t;

  localparam logic KIND_STEP  = 1'b0;
  localparam logic KIND_SPEED = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] string_key;
    logic [15:0] interval_ms;
    logic [15:0] text_length;
    logic [15:0] shown_count;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic        index_valid;
    logic [15:0] revealed_index;
    logic        shown_write;
    logic [15:0] new_shown;
  } rsp_t;

  // One channel entry as held in the slot memory.
  typedef struct packed {
    logic [15:0] key;
    logic [15:0] ticker;
    logic [15:0] interval;
    logic [31:0] last_time;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

// File: hdl/paced_reveal_channel_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paced_reveal_channel_table
// Table of paced reveal channels keyed by text handle, held in slot memory.
// ----------------------------------------------------------------------------
// Usage: a request beat on in_data (step or set-speed) is taken when in_valid
// and in_ready are high; exactly one response beat follows on out_data.
// Requests are handled one at a time. After acceptance the block scans the
// slot memory one entry per cycle through its registered read port, then
// decides and writes back the entry in S_EXEC. A scan ends at the first slot
// that matches, or after the last slot on a miss. Requests rejected by the
// early checks (zero handle, text fully shown, zero interval) skip the scan
// and go straight to S_EXEC. A new request is taken only once the previous
// one has been answered, since in_ready is high only in S_IDLE.
// The response sits in an output register, so in_ready returns while a beat
// still waits; if out_ready stays low, the next request stops before its
// write-back until the waiting beat is taken.
// Reset (rst_n low, synchronous) frees all slots through per-slot used flags;
// the memory itself needs no clearing pass.
// ----------------------------------------------------------------------------
module paced_reveal_channel_table
  import prct_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  state_t             state_r;
  req_t               req_r;
  logic [SLOTS-1:0]   used_r, used_nxt;
  logic [IDX_W-1:0]   scan_r;
  logic               chk_r;
  logic [IDX_W-1:0]   chk_idx_r;
  logic               hit_r;
  logic [IDX_W-1:0]   hit_idx_r;
  slot_t              hit_data_r;
  logic               out_valid_r;
  rsp_t               out_data_r;

  slot_t              rd_data;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  slot_t              ram_wdata;

  logic               in_fire;
  logic               exec_fire;
  logic               early;
  logic               free_any;
  logic [IDX_W-1:0]   free_idx;
  logic [31:0]        elapsed;
  logic [15:0]        tick_inc;
  logic               key_match;
  rsp_t               rsp_nxt;

  prct_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (state_r == S_SCAN),
    .raddr(scan_r),
    .rdata(rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign early = (in_data.string_key == 16'd0) ||
                 (in_data.text_length == in_data.shown_count) ||
                 (in_data.interval_ms == 16'd0);

  assign key_match = chk_r && used_r[chk_idx_r] && (rd_data.key == req_r.string_key);

  // First free slot, lowest index wins.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign elapsed  = req_r.now_ms - hit_data_r.last_time;
  assign tick_inc = hit_data_r.ticker + 16'd1;

  // Decision and write-back for the request in hand.
  always_comb begin
    rsp_nxt   = '0;
    used_nxt  = used_r;
    ram_we    = 1'b0;
    ram_waddr = hit_idx_r;
    ram_wdata = hit_data_r;
    priority if (req_r.string_key == 16'd0) begin
      rsp_nxt.status = ST_NOTEXT;
    end else if (req_r.text_length == req_r.shown_count) begin
      rsp_nxt.status = ST_DONE;
    end else if (req_r.interval_ms == 16'd0) begin
      rsp_nxt.status = ST_ERROR;
    end else if (req_r.kind == KIND_SPEED) begin
      if (hit_r) begin
        ram_we             = exec_fire;
        ram_wdata.interval = req_r.interval_ms;
        rsp_nxt.status     = ST_UPDATED;
      end else begin
        rsp_nxt.status = ST_ERROR;
      end
    end else if (!hit_r) begin
      if (free_any) begin
        ram_we              = exec_fire;
        ram_waddr           = free_idx;
        ram_wdata.key       = req_r.string_key;
        ram_wdata.ticker    = 16'd0;
        ram_wdata.interval  = req_r.interval_ms;
        ram_wdata.last_time = req_r.now_ms;
        used_nxt[free_idx]  = 1'b1;
        rsp_nxt.status      = ST_CREATED;
        rsp_nxt.shown_write = 1'b1;
        rsp_nxt.new_shown   = 16'd1;
      end else begin
        rsp_nxt.status = ST_ERROR;
      end
    end else if (elapsed <= {16'd0, hit_data_r.interval}) begin
      rsp_nxt.status = ST_WAITING;
    end else begin
      ram_we                 = exec_fire;
      ram_wdata.ticker       = tick_inc;
      ram_wdata.last_time    = req_r.now_ms;
      rsp_nxt.index_valid    = 1'b1;
      rsp_nxt.revealed_index = hit_data_r.ticker;
      rsp_nxt.shown_write    = 1'b1;
      rsp_nxt.new_shown      = tick_inc;
      if (tick_inc == req_r.text_length) begin
        // The text is fully revealed, so the channel is released.
        used_nxt[hit_idx_r] = 1'b0;
        rsp_nxt.status      = ST_DONE;
      end else begin
        rsp_nxt.status = ST_ADVANCE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      chk_r       <= 1'b0;
      hit_r       <= 1'b0;
      scan_r      <= '0;
    end else begin
      if (out_valid_r && out_ready && !exec_fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            req_r  <= in_data;
            hit_r  <= 1'b0;
            chk_r  <= 1'b0;
            scan_r <= '0;
            state_r <= early ? S_EXEC : S_SCAN;
          end
        end
        S_SCAN: begin
          chk_r     <= 1'b1;
          chk_idx_r <= scan_r;
          if (scan_r != LAST_IDX) begin
            scan_r <= scan_r + IDX_W'(1);
          end
          if (key_match) begin
            hit_r      <= 1'b1;
            hit_idx_r  <= chk_idx_r;
            hit_data_r <= rd_data;
            chk_r      <= 1'b0;
            state_r    <= S_EXEC;
          end else if (chk_r && (chk_idx_r == LAST_IDX)) begin
            chk_r   <= 1'b0;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            used_r      <= used_nxt;
            out_valid_r <= 1'b1;
            out_data_r  <= rsp_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // A hit always refers to a slot that is still in use.
  a_hit_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && hit_r) |-> used_r[hit_idx_r])
    else $error("hit slot is not marked used");

  // A new channel leaves its slot marked used.
  a_create_used: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && rsp_nxt.status == ST_CREATED) |=> used_r[$past(free_idx)])
    else $error("created channel slot not marked used");

  // Only a reveal reports an index.
  a_index_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.index_valid) |->
      (out_data_r.status == ST_ADVANCE || out_data_r.status == ST_DONE))
    else $error("index reported without a reveal");

  // The memory is written only while a response is produced.
  a_write_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> out_valid_r)
    else $error("slot write without a response beat");

endmodule

// File: hdl/prct_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prct_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module prct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
